FILE: rtl/core/vrag_pkg.sv
// ----------------------------------------------------------------------------
// vrag_pkg
// Shared types and constants for the volume reorientation address generator.
// ----------------------------------------------------------------------------
package vrag_pkg;

  localparam int LEN_BITS_DEF   = 12;  // counter width, lengths up to 1 << LEN_BITS
  localparam int NUM_AXES       = 4;
  localparam int CFG_LEN_W      = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 3;
  localparam int SRC_W          = 52;
  localparam int DST_W          = 50;
  localparam int DST_BYTES_LOG2 = 2;

  localparam logic [2:0] SRC_LOG2_MAX = 3'd4;

  // register reset values
  localparam logic [CFG_LEN_W-1:0] LEN_RST   = 13'd1;
  localparam logic [7:0]           ORDER_RST = 8'd228;  // identity order
  localparam logic [3:0]           FLIP_RST  = 4'd0;
  localparam logic [2:0]           SLOG_RST  = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN_X    = 3'd0,
    CFG_LEN_Y    = 3'd1,
    CFG_LEN_Z    = 3'd2,
    CFG_LEN_T    = 3'd3,
    CFG_ORDER    = 3'd4,
    CFG_FLIP     = 3'd5,
    CFG_SRC_LOG2 = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CFG_LEN_W-1:0] len;
    logic [7:0]                         axis_order;
    logic [3:0]                         flip_mask;
    logic [2:0]                         src_log2;
  } cfg_regs_t;

endpackage

FILE: rtl/core/volume_reorient_address_gen.sv
// ----------------------------------------------------------------------------
// volume_reorient_address_gen
// Source/destination address pair generator for reorienting a 4-D volume.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the in_ channel (valid/ready) is one scan tick. It yields one
//   word on the out_ channel: the source byte offset of the next voxel in
//   linear order, the byte offset of that voxel in the permuted/flipped
//   4-byte destination volume, and a last flag on the final voxel, after
//   which the scan wraps to zero. in_restart zeroes the scan before the tick.
//   Config is written through cfg_we/cfg_index/cfg_wdata while the block is
//   idle; writes take effect on the next clock.
// Throughput: one word per cycle, sustained while out_ready stays high. Each
//   word is registered through stage 1, stages 2 and 3 and the output
//   register, via three chained multiply-add stages (one axis length per stage).
// Reset: synchronous, active low. Counters return to the first voxel and all
//   config registers take their defaults (unit lengths, identity order).
// Stall: if out_ready is low the pipeline fills; in_ready drops only once all
//   four stages hold words, so bubbles are squeezed out first.
// ----------------------------------------------------------------------------
module volume_reorient_address_gen #(
  parameter int LEN_BITS = vrag_pkg::LEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vrag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vrag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vrag_pkg::SRC_W-1:0]        out_src_byte_offset,
  output logic [vrag_pkg::DST_W-1:0]        out_dst_byte_offset,
  output logic                              out_last
);
  import vrag_pkg::*;

  cfg_regs_t                         regs;
  logic [NUM_AXES-1:0][LEN_BITS:0]   len_eff;  // saturated input lengths
  logic [NUM_AXES-1:0][LEN_BITS:0]   tlen;     // destination lengths
  logic [2:0]                        src_shift;
  logic [NUM_AXES-1:0][LEN_BITS-1:0] cur_c;    // scan position of this word
  logic [NUM_AXES-1:0][LEN_BITS-1:0] dcoord;   // destination coordinates
  logic                              scan_last;
  logic                              acc;

  assign acc = in_valid && in_ready;

  vrag_cfg #(.LEN_BITS(LEN_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs),
    .len_eff   (len_eff),
    .tlen      (tlen),
    .src_shift (src_shift)
  );

  // counters advance on accept; coordinates feed stage 1 directly
  vrag_scan #(.LEN_BITS(LEN_BITS)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .restart (in_restart),
    .regs    (regs),
    .len_eff (len_eff),
    .cur_c   (cur_c),
    .dcoord  (dcoord),
    .last    (scan_last)
  );

  // offset = c0 + L0*(c1 + L1*(c2 + L2*c3)), one multiply-add per stage
  vrag_addr_pipe #(.LEN_BITS(LEN_BITS)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .c_in      (cur_c),
    .d_in      (dcoord),
    .last_in   (scan_last),
    .len_eff   (len_eff),
    .tlen      (tlen),
    .src_shift (src_shift),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .src_off   (out_src_byte_offset),
    .dst_off   (out_dst_byte_offset),
    .last      (out_last)
  );

endmodule

FILE: rtl/core/vrag_cfg.sv
// ----------------------------------------------------------------------------
// vrag_cfg
// Configuration register file plus derived lengths, permuted lengths and shift.
// ----------------------------------------------------------------------------
module vrag_cfg #(
  parameter int LEN_BITS = vrag_pkg::LEN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [vrag_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [vrag_pkg::CFG_DATA_W-1:0]             cfg_wdata,
  output vrag_pkg::cfg_regs_t                         regs,
  output logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS:0]   len_eff,
  output logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS:0]   tlen,
  output logic [2:0]                                  src_shift
);
  import vrag_pkg::*;

  localparam int unsigned        MAX_LEN   = 32'd1 << LEN_BITS;
  localparam logic [LEN_BITS:0]  MAX_LEN_V = (LEN_BITS+1)'(MAX_LEN);
  localparam logic [LEN_BITS:0]  ONE_LEN   = (LEN_BITS+1)'(1);

  cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEN_X:    regs_nxt.len[0]     = cfg_wdata[CFG_LEN_W-1:0];
        CFG_LEN_Y:    regs_nxt.len[1]     = cfg_wdata[CFG_LEN_W-1:0];
        CFG_LEN_Z:    regs_nxt.len[2]     = cfg_wdata[CFG_LEN_W-1:0];
        CFG_LEN_T:    regs_nxt.len[3]     = cfg_wdata[CFG_LEN_W-1:0];
        CFG_ORDER:    regs_nxt.axis_order = cfg_wdata[7:0];
        CFG_FLIP:     regs_nxt.flip_mask  = cfg_wdata[3:0];
        CFG_SRC_LOG2: regs_nxt.src_log2   = cfg_wdata[2:0];
        default:      regs_nxt = regs_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.len        <= {NUM_AXES{LEN_RST}};
      regs_r.axis_order <= ORDER_RST;
      regs_r.flip_mask  <= FLIP_RST;
      regs_r.src_log2   <= SLOG_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

  // length saturated to 1 .. 1 << LEN_BITS
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (regs_r.len[i] == '0) begin
        len_eff[i] = ONE_LEN;
      end else if (32'(regs_r.len[i]) > MAX_LEN) begin
        len_eff[i] = MAX_LEN_V;
      end else begin
        len_eff[i] = (LEN_BITS+1)'(32'(regs_r.len[i]));
      end
    end
  end

  // output-axis lengths: highest input axis mapped there wins
  always_comb begin
    tlen = {NUM_AXES{ONE_LEN}};
    for (int i = 0; i < NUM_AXES; i++) begin
      tlen[regs_r.axis_order[2*i +: 2]] = len_eff[i];
    end
  end

  assign src_shift = (regs_r.src_log2 > SRC_LOG2_MAX) ? SRC_LOG2_MAX : regs_r.src_log2;

endmodule

FILE: rtl/core/vrag_scan.sv
// ----------------------------------------------------------------------------
// vrag_scan
// Four nested scan counters; emits current and mirrored/permuted coordinates.
// ----------------------------------------------------------------------------
module vrag_scan #(
  parameter int LEN_BITS = vrag_pkg::LEN_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          acc,
  input  logic                                          restart,
  input  vrag_pkg::cfg_regs_t                           regs,
  input  logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS:0]     len_eff,
  output logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS-1:0]   cur_c,
  output logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS-1:0]   dcoord,
  output logic                                          last
);
  import vrag_pkg::*;

  logic [NUM_AXES-1:0][LEN_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_AXES-1:0][LEN_BITS-1:0] lenm1;
  logic [NUM_AXES-1:0]               at_end;

  assign cur_c = restart ? '0 : cnt_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lenm1[i]  = LEN_BITS'(len_eff[i] - (LEN_BITS+1)'(1));
      at_end[i] = cur_c[i] >= lenm1[i];
    end
  end

  assign last = &at_end;

  // lowest input axis mapped to an output axis supplies its coordinate
  always_comb begin
    logic [1:0]          o;
    logic [LEN_BITS-1:0] coord;
    logic [NUM_AXES-1:0] dset;
    dset   = '0;
    dcoord = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      o     = regs.axis_order[2*i +: 2];
      coord = regs.flip_mask[i] ? LEN_BITS'(lenm1[i] - cur_c[i]) : cur_c[i];
      if (!dset[o]) begin
        dcoord[o] = coord;
        dset[o]   = 1'b1;
      end
    end
  end

  // ripple carry; a counter at or past its end wraps to zero
  always_comb begin
    logic carry;
    carry   = 1'b1;
    cnt_nxt = cur_c;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (carry) begin
        if (at_end[i]) begin
          cnt_nxt[i] = '0;
        end else begin
          cnt_nxt[i] = LEN_BITS'(cur_c[i] + LEN_BITS'(1));
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> cnt_r == '0)
    else $error("counters did not wrap after final voxel");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(cnt_r))
    else $error("counters moved without an accepted word");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !last |=> cnt_r != $past(cur_c))
    else $error("counters failed to advance");

endmodule

FILE: rtl/core/vrag_addr_pipe.sv
// ----------------------------------------------------------------------------
// vrag_addr_pipe
// Three-stage multiply-accumulate pipeline for source and destination offsets.
// ----------------------------------------------------------------------------
module vrag_addr_pipe #(
  parameter int LEN_BITS = vrag_pkg::LEN_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS-1:0]   c_in,
  input  logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS-1:0]   d_in,
  input  logic                                          last_in,
  input  logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS:0]     len_eff,
  input  logic [vrag_pkg::NUM_AXES-1:0][LEN_BITS:0]     tlen,
  input  logic [2:0]                                    src_shift,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [vrag_pkg::SRC_W-1:0]                    src_off,
  output logic [vrag_pkg::DST_W-1:0]                    dst_off,
  output logic                                          last
);
  import vrag_pkg::*;

  localparam int W2 = 2 * LEN_BITS;
  localparam int W3 = 3 * LEN_BITS;
  localparam int W4 = 4 * LEN_BITS;

  // stage 1: captured coordinates
  logic                              v1_r, l1_r;
  logic [NUM_AXES-1:0][LEN_BITS-1:0] c1_r, d1_r;
  // stage 2: innermost product
  logic                              v2_r, l2_r;
  logic [W2-1:0]                     ps2_r, pd2_r;
  logic [1:0][LEN_BITS-1:0]          c2_r, d2_r;
  // stage 3: middle product
  logic                              v3_r, l3_r;
  logic [W3-1:0]                     ps3_r, pd3_r;
  logic [LEN_BITS-1:0]               c3_r, d3_r;
  // output register
  logic                              out_valid_r, last_r;
  logic [SRC_W-1:0]                  src_r;
  logic [DST_W-1:0]                  dst_r;

  logic rdy_out, rdy3, rdy2, rdy1;
  logic [W2-1:0] ps2_nxt, pd2_nxt;
  logic [W3-1:0] ps3_nxt, pd3_nxt;
  logic [W4-1:0] slin, dlin;

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ps2_nxt = W2'(len_eff[2]) * W2'(c1_r[3]) + W2'(c1_r[2]);
  assign pd2_nxt = W2'(tlen[2]) * W2'(d1_r[3]) + W2'(d1_r[2]);
  assign ps3_nxt = W3'(len_eff[1]) * W3'(ps2_r) + W3'(c2_r[1]);
  assign pd3_nxt = W3'(tlen[1]) * W3'(pd2_r) + W3'(d2_r[1]);
  assign slin    = W4'(len_eff[0]) * W4'(ps3_r) + W4'(c3_r);
  assign dlin    = W4'(tlen[0]) * W4'(pd3_r) + W4'(d3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_r <= c_in;
      d1_r <= d_in;
      l1_r <= last_in;
    end
    if (rdy2) begin
      ps2_r <= ps2_nxt;
      pd2_r <= pd2_nxt;
      c2_r  <= {c1_r[1], c1_r[0]};
      d2_r  <= {d1_r[1], d1_r[0]};
      l2_r  <= l1_r;
    end
    if (rdy3) begin
      ps3_r <= ps3_nxt;
      pd3_r <= pd3_nxt;
      c3_r  <= c2_r[0];
      d3_r  <= d2_r[0];
      l3_r  <= l2_r;
    end
    if (rdy_out) begin
      src_r  <= SRC_W'(slin) << src_shift;
      dst_r  <= DST_W'(dlin) << DST_BYTES_LOG2;
      last_r <= l3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign src_off   = src_r;
  assign dst_off   = dst_r;
  assign last      = last_r;

  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy_out |=> out_valid_r)
    else $error("stage 3 word lost on the way to output");

  a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !v3_r |=> !out_valid_r)
    else $error("output word repeated after being taken");

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted word not captured in stage 1");

endmodule

FILE: bench/tb_volume_reorient_address_gen.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_volume_reorient_address_gen
// Self-checking bench for the 4-D volume reorientation address generator.
// A table of hand-picked scan ticks and register writes runs first: unit
// volumes after reset, a small flipped volume typed out voxel by voxel,
// saturated lengths and sizes, swapped, collapsed and repeated axis orders,
// and lengths shrunk mid-scan. Random register settings and tick bursts
// follow. Every output word is compared field by field with an in-bench
// scan model fed from the accepted input words, unless a value is typed.
// ----------------------------------------------------------------------------
module tb_volume_reorient_address_gen;
  import vrag_pkg::*;

  localparam int          LAT          = 3;     // settle margin base, used by settle()
  localparam int          RANDOM_TICKS = 1930;
  localparam int          STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int          HOLD_CYCLES  = 150;   // one long receiver hold-off
  localparam int          ERR_PRINTS   = 40;
  localparam logic [31:0] MAX_LEN      = 32'd1 << LEN_BITS_DEF;
  localparam logic [31:0] CNT_MASK     = MAX_LEN - 32'd1;

  // one output word
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic             last;
  } addr_word_t;

  // a word with a hand-typed value overrides the scan model for that tick
  typedef struct packed {
    logic       fixed;
    addr_word_t word;
  } typed_word_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    typed_word_t           typed;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SRC_W-1:0]      out_src_byte_offset;
  logic [DST_W-1:0]      out_dst_byte_offset;
  logic                  out_last;

  // shadow of the register file and the scan counters
  logic [CFG_LEN_W-1:0]  len_reg [NUM_AXES];
  logic [7:0]            order_reg;
  logic [3:0]            flip_reg;
  logic [2:0]            slog_reg;
  logic [LEN_BITS_DEF-1:0] scan_pos [NUM_AXES];

  addr_word_t  pending_addr_q [$];  // expected words, oldest first
  typed_word_t typed_addr_q [$];    // one entry per offered tick
  int          err_count = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  volume_reorient_address_gen i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_src_byte_offset (out_src_byte_offset),
    .out_dst_byte_offset (out_dst_byte_offset),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scan model: one tick in, one address pair out, counters advanced.
  // --------------------------------------------------------------------------
  function automatic addr_word_t reorient_tick(input logic restart);
    logic [31:0] span_len [NUM_AXES];
    logic [63:0] dst_len [NUM_AXES];
    logic [63:0] dst_pos [NUM_AXES];
    logic        dst_set [NUM_AXES];
    logic        at_end [NUM_AXES];
    logic [31:0] c;
    logic [1:0]  o;
    logic [63:0] lin, src_full, dst_full;
    logic [2:0]  slog;
    logic        carry;
    addr_word_t  w;
    int          a;
    // zero and oversized lengths saturate into 1 .. 1 << LEN_BITS
    for (a = 0; a < NUM_AXES; a++) begin
      if (len_reg[a] == '0) span_len[a] = 32'd1;
      else if (32'(len_reg[a]) > MAX_LEN) span_len[a] = MAX_LEN;
      else span_len[a] = 32'(len_reg[a]);
    end
    if (restart) begin
      for (a = 0; a < NUM_AXES; a++) scan_pos[a] = '0;
    end
    // a counter left past a shrunk length simply counts as at its end
    for (a = 0; a < NUM_AXES; a++) begin
      dst_len[a] = 64'd1;
      dst_pos[a] = 64'd0;
      dst_set[a] = 1'b0;
      at_end[a]  = 32'(scan_pos[a]) >= span_len[a] - 32'd1;
    end
    // length from the highest input axis landing on an output axis,
    // coordinate from the lowest one; unused output axes stay 1 / 0
    for (a = 0; a < NUM_AXES; a++) begin
      o = order_reg[2*a +: 2];
      dst_len[o] = 64'(span_len[a]);
      if (!dst_set[o]) begin
        c = 32'(scan_pos[a]);
        if (flip_reg[a]) c = (span_len[a] - 32'd1 - c) & CNT_MASK;
        dst_pos[o] = 64'(c);
        dst_set[o] = 1'b1;
      end
    end
    lin = 64'(scan_pos[0]) + 64'(span_len[0]) * (64'(scan_pos[1]) +
          64'(span_len[1]) * (64'(scan_pos[2]) + 64'(span_len[2]) * 64'(scan_pos[3])));
    slog = (slog_reg > SRC_LOG2_MAX) ? SRC_LOG2_MAX : slog_reg;
    src_full = lin << slog;
    dst_full = dst_pos[0] + dst_len[0] * (dst_pos[1] + dst_len[1] *
               (dst_pos[2] + dst_len[2] * dst_pos[3]));
    dst_full = dst_full << DST_BYTES_LOG2;
    w.src  = src_full[SRC_W-1:0];
    w.dst  = dst_full[DST_W-1:0];
    w.last = at_end[0] && at_end[1] && at_end[2] && at_end[3];
    // ripple carry; the final voxel wraps every axis back to zero
    carry = 1'b1;
    for (a = 0; a < NUM_AXES; a++) begin
      if (carry) begin
        if (at_end[a]) begin
          scan_pos[a] = '0;
        end else begin
          scan_pos[a] = scan_pos[a] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return w;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_t idx, input int value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = value[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic restart);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_TICK;
    r.restart = restart;
    return r;
  endfunction

  function automatic plan_row_t tick_chk(input logic restart, input logic [SRC_W-1:0] src,
                                         input logic [DST_W-1:0] dst, input logic last);
    plan_row_t r;
    r = tick_row(restart);
    r.typed = '{fixed: 1'b1, word: '{src: src, dst: dst, last: last}};
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    err_count++;
    if (err_count <= ERR_PRINTS)
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between bursts.
  // Valid stays up with the word unchanged until in_ready takes it.
  // --------------------------------------------------------------------------
  task automatic push_tick(input logic restart, input typed_word_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    typed_addr_q.push_back(typed);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // drop valid, let every expected word come back, then a few spare cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_addr_q.size() != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  // caller lowers cfg_we once the batch of writes is done
  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_LEN_X:    len_reg[0] = value;
      CFG_LEN_Y:    len_reg[1] = value;
      CFG_LEN_Z:    len_reg[2] = value;
      CFG_LEN_T:    len_reg[3] = value;
      CFG_ORDER:    order_reg  = value[7:0];
      CFG_FLIP:     flip_reg   = value[3:0];
      CFG_SRC_LOG2: slog_reg   = value[2:0];
      default: ;
    endcase
  endtask

  // mostly short axes so scans wrap often; now and then the extremes
  function automatic logic [CFG_DATA_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 5));
    if (r < 85) return CFG_DATA_W'($urandom_range(1, 64));
    if (r < 95) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CFG_DATA_W'(1);
        2: return CFG_DATA_W'(MAX_LEN);
        default: return CFG_DATA_W'($urandom_range(MAX_LEN + 1, 8191));
      endcase
    end
    return CFG_DATA_W'($urandom_range(0, 8191));
  endfunction

  // mostly true permutations, sometimes any byte (collapsed axes)
  function automatic logic [CFG_DATA_W-1:0] pick_order();
    logic [1:0] perm [NUM_AXES];
    logic [1:0] t;
    logic [7:0] v;
    int         a, b;
    if ($urandom_range(0, 9) < 3) return CFG_DATA_W'($urandom_range(0, 255));
    for (a = 0; a < NUM_AXES; a++) perm[a] = a[1:0];
    for (a = NUM_AXES - 1; a > 0; a--) begin
      b = $urandom_range(0, a);
      t = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    end
    v = {perm[3], perm[2], perm[1], perm[0]};
    return CFG_DATA_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Checker: accepted ticks feed the scan model, output words are compared
  // against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    addr_word_t  want;
    typed_word_t typed;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want  = reorient_tick(in_restart);
        typed = typed_addr_q.pop_front();
        if (typed.fixed) want = typed.word;
        pending_addr_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_addr_q.size() == 0) begin
          err_count++;
          if (err_count <= ERR_PRINTS)
            $display("%0t unexpected word: expected none actual src %0h dst %0h last %0b",
                     $time, out_src_byte_offset, out_dst_byte_offset, out_last);
        end else begin
          want = pending_addr_q.pop_front();
          if (out_src_byte_offset !== want.src)
            note_mismatch("src_byte_offset", 64'(want.src), 64'(out_src_byte_offset));
          if (out_dst_byte_offset !== want.dst)
            note_mismatch("dst_byte_offset", 64'(want.dst), 64'(out_dst_byte_offset));
          if (out_last !== want.last)
            note_mismatch("last", 64'(want.last), 64'(out_last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: runs of always-ready, coin-flip and fixed duty patterns; one
  // long hold-off on request so the pipeline fills and in_ready drops.
  // --------------------------------------------------------------------------
  initial begin : rx_pace
    int mode, span, k;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (k = 0; k < span; k++) begin
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 4) != 3;
          default: out_ready <= (k % 8) < 2;
        endcase
        @(posedge clk);
      end
    end
  end

  // no handshake on either side for too long ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan [$];
    bit        writing;
    int        sent, phase, n, k;
    cfg_idx_t  ridx;

    // register and counter state after reset
    for (k = 0; k < NUM_AXES; k++) begin
      len_reg[k]  = LEN_RST;
      scan_pos[k] = '0;
    end
    order_reg = ORDER_RST;
    flip_reg  = FLIP_RST;
    slog_reg  = SLOG_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = '{
      // unit volume after reset: every tick is voxel 0 and the last one
      tick_chk(1'b0, '0, '0, 1'b1),
      tick_chk(1'b1, '0, '0, 1'b1),
      // 3 x 2 volume, x mirrored, 1-byte source voxels
      cfg_row(CFG_LEN_X, 3), cfg_row(CFG_LEN_Y, 2),
      cfg_row(CFG_FLIP, 1), cfg_row(CFG_SRC_LOG2, 0),
      tick_chk(1'b0, 52'd0, 50'd8, 1'b0),
      tick_chk(1'b0, 52'd1, 50'd4, 1'b0),
      tick_chk(1'b0, 52'd2, 50'd0, 1'b0),
      tick_chk(1'b0, 52'd3, 50'd20, 1'b0),
      tick_chk(1'b0, 52'd4, 50'd16, 1'b0),
      tick_chk(1'b0, 52'd5, 50'd12, 1'b1),
      tick_chk(1'b0, 52'd0, 50'd8, 1'b0),   // wrapped
      tick_chk(1'b0, 52'd1, 50'd4, 1'b0),
      tick_chk(1'b1, 52'd0, 50'd8, 1'b0),   // restart mid-scan
      // saturated lengths and size, x and t swapped, all mirrored
      cfg_row(CFG_LEN_X, 8191), cfg_row(CFG_LEN_Y, 0), cfg_row(CFG_LEN_Z, 0),
      cfg_row(CFG_LEN_T, 4096), cfg_row(CFG_ORDER, 39), cfg_row(CFG_FLIP, 15),
      cfg_row(CFG_SRC_LOG2, 7),
      tick_chk(1'b1, 52'd0, 50'd67108860, 1'b0),
      tick_row(1'b0), tick_row(1'b0),
      // widen y mid-scan, largest legal source voxel
      cfg_row(CFG_SRC_LOG2, 4), cfg_row(CFG_LEN_Y, 4096),
      tick_row(1'b0), tick_row(1'b0),
      // shrink below the running x counter, every axis onto output 0
      cfg_row(CFG_LEN_X, 2), cfg_row(CFG_LEN_Y, 3), cfg_row(CFG_LEN_Z, 2),
      cfg_row(CFG_LEN_T, 2), cfg_row(CFG_ORDER, 0),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
      // every axis onto output 3, y and z mirrored
      cfg_row(CFG_ORDER, 255), cfg_row(CFG_FLIP, 6),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b1)
    };

    writing = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        put_reg(plan[r].idx, plan[r].data);
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        push_tick(plan[r].restart, plan[r].typed);
      end
    end

    // random phases: new settings while idle, then a burst of ticks
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_TICKS) begin
      settle();
      for (k = 0; k <= int'(CFG_SRC_LOG2); k++) begin
        if ($urandom_range(0, 1) == 1) begin
          ridx = cfg_idx_t'(k);
          case (ridx)
            CFG_ORDER:    put_reg(ridx, pick_order());
            CFG_FLIP:     put_reg(ridx, CFG_DATA_W'($urandom_range(0, 15)));
            CFG_SRC_LOG2: put_reg(ridx, CFG_DATA_W'($urandom_range(0, 7)));
            default:      put_reg(ridx, pick_len());
          endcase
        end
      end
      cfg_we <= 1'b0;
      n = $urandom_range(8, 120);
      if (phase == 3) begin
        // back-pressure phase: steady offering while the receiver holds off
        hold_req   = 1'b1;
        burst_left = 200;
        n = 80;
      end
      for (k = 0; k < n; k++) push_tick($urandom_range(0, 31) == 0, '0);
      sent += n;
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
